FILE: hdl/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types and defaults for the transaction slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

  // Default geometry
  localparam int unsigned SLOT_COUNT_DEF = 48;
  localparam int unsigned WRAP_LIMIT_DEF = 65535;

  // Request opcodes
  typedef enum logic [2:0] {
    OP_ALLOC     = 3'd0,
    OP_FREE      = 3'd1,
    OP_MARK_COMM = 3'd2,
    OP_MARK_ABRT = 3'd3,
    OP_ROLLOVER  = 3'd4,
    OP_READ_WRAP = 3'd5
  } op_e;

  // Slot status codes
  typedef enum logic [1:0] {
    SLOT_FREE      = 2'd0,
    SLOT_ACTIVE    = 2'd1,
    SLOT_COMMITTED = 2'd2,
    SLOT_ABORTED   = 2'd3
  } slot_st_e;

  // Result status codes
  typedef enum logic [1:0] {
    RES_OK     = 2'd0,
    RES_NONE   = 2'd1,
    RES_BADARG = 2'd2
  } res_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_GRANT,
    S_RMW,
    S_DONE
  } state_e;

  // One slot table entry
  typedef struct packed {
    slot_st_e    status;
    logic [31:0] owner;
    logic [15:0] wrap;
    logic [63:0] cnum;
  } slot_t;

endpackage

`default_nettype wire

FILE: hdl/transaction_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// transaction_slot_allocator_top: slot table in one sync RAM with a scan sequencer
// Allocate is paced by the scan, which reads one slot at a time through the one read
// port. Free, mark and read wrap do a read and then a modify/write; others skip the RAM.
// One request is handled at a time; the next can be taken from the cycle in which the
// result is first presented.
// Reset or rollover clears the per-slot valid flops at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module transaction_slot_allocator_top #(
  parameter int unsigned SLOT_COUNT = tsa_pkg::SLOT_COUNT_DEF,
  parameter int unsigned WRAP_LIMIT = tsa_pkg::WRAP_LIMIT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_wr_en_i,
  input  wire logic        cfg_wr_data_i,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [31:0] owner_id_i,
  input  wire logic [5:0]  slot_index_i,
  input  wire logic [63:0] commit_number_i,
  input  wire logic [63:0] horizon_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_status_o,
  output logic [5:0]       granted_slot_o,
  output logic             retain_block_o,
  output logic             prior_active_o,
  output logic [15:0]      wrap_value_o
);

  import tsa_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(SLOT_COUNT - 1);
  localparam logic [15:0] WrapMax = 16'(WRAP_LIMIT);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   gate_q;
  logic [SLOT_COUNT-1:0] valid_q;
  logic [CNT_W-1:0] act_cnt_q;

  // latched request
  op_e         req_op_q;
  logic [31:0] req_owner_q;
  logic [63:0] req_cnum_q;
  logic [63:0] req_horizon_q;

  // scan state
  logic [IDX_W-1:0] scan_q;
  logic             iss_done_q;
  logic             chk_vld_q;
  logic [IDX_W-1:0] chk_idx_q;
  logic             free_fnd_q, reuse_fnd_q, press_q;
  logic [IDX_W-1:0] free_idx_q, reuse_idx_q;
  logic [15:0]      free_wrap_q, reuse_wrap_q;

  // RMW address
  logic [IDX_W-1:0] rmw_addr_q;

  // memory and read port
  slot_t mem_q [SLOT_COUNT];
  slot_t rd_data_q;
  logic  rd_vld_q;

  // staged result
  res_e             res_status_q;
  logic [IDX_W-1:0] res_slot_q;
  logic             res_press_q;
  logic             res_had_act_q;
  logic [15:0]      res_wrap_q;

  // output register
  logic        out_valid_q;
  res_e        out_status_q;
  logic [5:0]  out_slot_q;
  logic        out_press_q;
  logic        out_had_act_q;
  logic [15:0] out_wrap_q;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic             in_accept;
  logic [IDX_W+5:0] idx_ext;
  logic             in_idx_ok;
  logic [IDX_W-1:0] in_addr;
  op_e              in_op;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_op      = op_e'(op_i);
  assign idx_ext    = {{IDX_W{1'b0}}, slot_index_i};
  assign in_idx_ok  = idx_ext < (IDX_W + 6)'(SLOT_COUNT);
  assign in_addr    = in_idx_ok ? idx_ext[IDX_W-1:0] : '0;

  // --------------------------------------------------------------------------
  // Entry under inspection: never-written slots read as zero (free)
  // --------------------------------------------------------------------------
  slot_t cur_e;
  logic  owner_hit, retained, recyclable, last_chk;

  assign cur_e      = rd_vld_q ? rd_data_q : '0;
  assign owner_hit  = (cur_e.status == SLOT_ACTIVE) && (cur_e.owner == req_owner_q);
  assign retained   = gate_q && (cur_e.status == SLOT_COMMITTED) &&
                      !(cur_e.cnum < req_horizon_q);
  assign recyclable = ((cur_e.status == SLOT_COMMITTED) ||
                       (cur_e.status == SLOT_ABORTED)) && !retained;
  assign last_chk   = chk_vld_q && (chk_idx_q == LastIdx);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_ALLOC: begin
              state_d = (owner_id_i == 32'd0) ? S_DONE : S_SCAN;
            end
            OP_FREE, OP_MARK_COMM, OP_MARK_ABRT, OP_READ_WRAP: begin
              state_d = in_idx_ok ? S_RMW : S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (chk_vld_q && owner_hit) begin
          state_d = S_DONE;
        end else if (last_chk) begin
          state_d = S_GRANT;
        end
      end
      S_GRANT: state_d = S_DONE;
      S_RMW:   state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs: memory port, counter updates, result staging
  // --------------------------------------------------------------------------
  logic             mem_re, mem_we, scan_iss, clr_all, cnt_inc, cnt_dec, out_ld;
  logic [IDX_W-1:0] mem_raddr, mem_waddr;
  slot_t            mem_wdata;
  logic             res_ld;
  res_e             res_status_d;
  logic [IDX_W-1:0] res_slot_d;
  logic             res_press_d, res_had_act_d;
  logic [15:0]      res_wrap_d;

  always_comb begin
    mem_re        = 1'b0;
    mem_raddr     = scan_q;
    mem_we        = 1'b0;
    mem_waddr     = rmw_addr_q;
    mem_wdata     = cur_e;
    scan_iss      = 1'b0;
    clr_all       = 1'b0;
    cnt_inc       = 1'b0;
    cnt_dec       = 1'b0;
    out_ld        = 1'b0;
    res_ld        = 1'b0;
    res_status_d  = RES_OK;
    res_slot_d    = '0;
    res_press_d   = 1'b0;
    res_had_act_d = 1'b0;
    res_wrap_d    = '0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_ALLOC: begin
              if (owner_id_i == 32'd0) begin
                res_ld       = 1'b1;
                res_status_d = RES_BADARG;
              end
            end
            OP_FREE, OP_MARK_COMM, OP_MARK_ABRT, OP_READ_WRAP: begin
              if (in_idx_ok) begin
                mem_re    = 1'b1;
                mem_raddr = in_addr;
              end else begin
                res_ld       = 1'b1;
                res_status_d = RES_BADARG;
              end
            end
            OP_ROLLOVER: begin
              res_ld        = 1'b1;
              res_had_act_d = (act_cnt_q != '0);
              clr_all       = 1'b1;
            end
            default: begin
              res_ld       = 1'b1;
              res_status_d = RES_BADARG;
            end
          endcase
        end
      end
      S_SCAN: begin
        // one read issued per cycle, checked in the following cycle
        if (!iss_done_q) begin
          mem_re   = 1'b1;
          scan_iss = 1'b1;
        end
        if (chk_vld_q && owner_hit) begin
          res_ld     = 1'b1;
          res_slot_d = chk_idx_q;
        end
      end
      S_GRANT: begin
        res_ld           = 1'b1;
        mem_wdata.status = SLOT_ACTIVE;
        mem_wdata.owner  = req_owner_q;
        mem_wdata.cnum   = '0;
        if (free_fnd_q) begin
          mem_we         = 1'b1;
          mem_waddr      = free_idx_q;
          mem_wdata.wrap = free_wrap_q;
          cnt_inc        = 1'b1;
          res_slot_d     = free_idx_q;
        end else if (reuse_fnd_q) begin
          mem_we         = 1'b1;
          mem_waddr      = reuse_idx_q;
          mem_wdata.wrap = (reuse_wrap_q < WrapMax) ? reuse_wrap_q + 16'd1 : reuse_wrap_q;
          cnt_inc        = 1'b1;
          res_slot_d     = reuse_idx_q;
        end else begin
          res_status_d = RES_NONE;
          res_press_d  = press_q;
        end
      end
      S_RMW: begin
        res_ld = 1'b1;
        case (req_op_q)
          OP_FREE: begin
            mem_we           = 1'b1;
            mem_wdata.status = SLOT_FREE;
            mem_wdata.owner  = '0;
            mem_wdata.cnum   = '0;
            cnt_dec          = (cur_e.status == SLOT_ACTIVE);
          end
          OP_MARK_COMM: begin
            if (owner_hit) begin
              mem_we           = 1'b1;
              mem_wdata.status = SLOT_COMMITTED;
              mem_wdata.cnum   = req_cnum_q;
              cnt_dec          = 1'b1;
            end
          end
          OP_MARK_ABRT: begin
            if (owner_hit) begin
              mem_we           = 1'b1;
              mem_wdata.status = SLOT_ABORTED;
              mem_wdata.cnum   = '0;
              cnt_dec          = 1'b1;
            end
          end
          OP_READ_WRAP: begin
            res_wrap_d = cur_e.wrap;
          end
          default: begin
            res_status_d = RES_BADARG;
          end
        endcase
      end
      S_DONE: begin
        out_ld = out_free;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gate_q      <= 1'b0;
      valid_q     <= '0;
      act_cnt_q   <= '0;
      iss_done_q  <= 1'b0;
      chk_vld_q   <= 1'b0;
      free_fnd_q  <= 1'b0;
      reuse_fnd_q <= 1'b0;
      press_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        gate_q <= cfg_wr_data_i;
      end
      // valid flags and active count
      if (clr_all) begin
        valid_q   <= '0;
        act_cnt_q <= '0;
      end else begin
        if (mem_we) begin
          valid_q[mem_waddr] <= 1'b1;
        end
        if (cnt_inc) begin
          act_cnt_q <= act_cnt_q + CNT_W'(1);
        end else if (cnt_dec) begin
          act_cnt_q <= act_cnt_q - CNT_W'(1);
        end
      end
      if (mem_re) begin
        rd_vld_q <= valid_q[mem_raddr];
      end
      // scan bookkeeping
      chk_vld_q <= scan_iss;
      if (in_accept) begin
        iss_done_q  <= 1'b0;
        free_fnd_q  <= 1'b0;
        reuse_fnd_q <= 1'b0;
        press_q     <= 1'b0;
      end else begin
        if (scan_iss && (scan_q == LastIdx)) begin
          iss_done_q <= 1'b1;
        end
        if ((state_q == S_SCAN) && chk_vld_q) begin
          if (cur_e.status == SLOT_FREE) begin
            free_fnd_q <= 1'b1;
          end
          if (recyclable) begin
            reuse_fnd_q <= 1'b1;
          end
          if (retained) begin
            press_q <= 1'b1;
          end
        end
      end
      // output register
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  logic [IDX_W+5:0] res_slot_ext;
  assign res_slot_ext = {6'd0, res_slot_q};

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_op_q      <= in_op;
      req_owner_q   <= owner_id_i;
      req_cnum_q    <= commit_number_i;
      req_horizon_q <= horizon_i;
      rmw_addr_q    <= in_addr;
      scan_q        <= '0;
    end else if (scan_iss && (scan_q != LastIdx)) begin
      scan_q <= scan_q + IDX_W'(1);
    end
    if (scan_iss) begin
      chk_idx_q <= scan_q;
    end
    // first free / first recyclable slot seen
    if ((state_q == S_SCAN) && chk_vld_q) begin
      if ((cur_e.status == SLOT_FREE) && !free_fnd_q) begin
        free_idx_q  <= chk_idx_q;
        free_wrap_q <= cur_e.wrap;
      end
      if (recyclable && !reuse_fnd_q) begin
        reuse_idx_q  <= chk_idx_q;
        reuse_wrap_q <= cur_e.wrap;
      end
    end
    if (res_ld) begin
      res_status_q  <= res_status_d;
      res_slot_q    <= res_slot_d;
      res_press_q   <= res_press_d;
      res_had_act_q <= res_had_act_d;
      res_wrap_q    <= res_wrap_d;
    end
    if (out_ld) begin
      out_status_q  <= res_status_q;
      out_slot_q    <= res_slot_ext[5:0];
      out_press_q   <= res_press_q;
      out_had_act_q <= res_had_act_q;
      out_wrap_q    <= res_wrap_q;
    end
  end

  // --------------------------------------------------------------------------
  // Slot table RAM: one write, one registered read
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign out_valid_o     = out_valid_q;
  assign result_status_o = out_status_q;
  assign granted_slot_o  = out_slot_q;
  assign retain_block_o  = out_press_q;
  assign prior_active_o  = out_had_act_q;
  assign wrap_value_o    = out_wrap_q;

`ifndef NO_ASSERTIONS
  // a new result only comes out of the delivery state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result appeared outside delivery state");

  // rollover leaves no active slot behind
  a_rollover_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_op == OP_ROLLOVER)) |=> (act_cnt_q == '0) && (valid_q == '0))
    else $error("rollover did not clear the table");

  // active count stays within the table
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_cnt_q <= CNT_W'(SLOT_COUNT))
    else $error("active slot count out of range");

  // RAM is never written during the scan
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !mem_we)
    else $error("table write during scan");
`endif

endmodule

`default_nettype wire
